[hw/rtl/aaq_pkg.sv]
`timescale 1ns / 1ps

package aaq_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Engineering value width (signed Q16.16)
  localparam int VAL_W = 32;

  // Reset value of the full-code engineering value: 100.0 in Q16.16
  localparam logic signed [VAL_W-1:0] VAL_FULL_RST = 32'sd6553600;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALARM_TYPE     = 3'd0,
    CFG_VAL_ZERO       = 3'd1,
    CFG_VAL_FULL       = 3'd2,
    CFG_VALUE_OFFSET   = 3'd3,
    CFG_SET_POINT      = 3'd4,
    CFG_RESET_POINT    = 3'd5,
    CFG_TIME_TO_ALARM  = 3'd6,
    CFG_TIME_TO_RETURN = 3'd7
  } cfg_idx_e;

  // Alarm kinds
  typedef enum logic [1:0] {
    ALARM_HIGH     = 2'd0,
    ALARM_LOW      = 2'd1,
    ALARM_IN_BAND  = 2'd2,
    ALARM_OUT_BAND = 2'd3
  } alarm_type_e;

  // Per-channel alarm qualification state
  typedef struct packed {
    logic        in_alarm;
    logic        alarm_pending;
    logic [31:0] alarm_start;
    logic        return_pending;
    logic [31:0] return_start;
  } chan_state_t;

endpackage

[hw/rtl/aaq_if.sv]
`timescale 1ns / 1ps

// Reading channel: one averaged converter reading per transfer
interface aaq_in_if #(
  parameter int CH_W  = 1,
  parameter int ADC_W = 12
);
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [ADC_W-1:0] adc_code;
  logic [31:0]      now_ms;

  modport source (output valid, output channel, output adc_code, output now_ms,
                  input ready);
  modport sink   (input valid, input channel, input adc_code, input now_ms,
                  output ready);
endinterface

// Result channel: scaled value and alarm status per transfer
interface aaq_out_if #(
  parameter int CH_W = 1
);
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    channel_out;
  logic signed [31:0] eng_value;
  logic               alarm_active;
  logic               alarm_raised;
  logic               alarm_cleared;

  modport source (output valid, output channel_out, output eng_value,
                  output alarm_active, output alarm_raised, output alarm_cleared,
                  input ready);
  modport sink   (input valid, input channel_out, input eng_value,
                  input alarm_active, input alarm_raised, input alarm_cleared,
                  output ready);
endinterface

[hw/rtl/analog_alarm_qualifier.sv]
`timescale 1ns / 1ps

// Process alarm qualifier. Each reading is scaled linearly to a signed Q16.16
// engineering value (code 0 gives the 4 mA value, full code gives the 20 mA
// value, rounded to nearest, then value_offset is added and the sum saturated),
// then checked against a high, low, in-band or out-of-band alarm with set and
// reset points. Entering or leaving alarm needs the condition on two or more
// scans that span at least time_to_alarm or time_to_return ms (wrap-safe). The
// block accepts one reading per clock unless a stalled result fills every slot;
// each result passes through a five-register pipeline (input, product,
// partial divide by the full-scale code, saturated value, result). Any empty
// pipeline slot absorbs a stalled result, so readings keep flowing until every
// slot is full. Readings for a channel number at or above CHANNELS are dropped
// without a result. Configuration is shared by all channels and is used by each
// stage as a reading passes it, so a write also reaches readings in flight.
module analog_alarm_qualifier
  import aaq_pkg::*;
#(
  parameter int CHANNELS = 2,
  parameter int ADC_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  aaq_in_if.sink                in_i,
  aaq_out_if.source             out_o
);

  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int X_W      = ADC_BITS + 33;
  localparam int FOLD_N   = X_W / (ADC_BITS - 1) + 3;
  localparam int FOLD_A   = 2;
  localparam int FOLD_B   = FOLD_N - FOLD_A;
  localparam logic [X_W-1:0] CODE_MAX = (X_W'(1) << ADC_BITS) - X_W'(1);
  localparam logic [X_W-1:0] HALF     = CODE_MAX >> 1;
  localparam logic signed [34:0] V_MAX = 35'sd2147483647;
  localparam logic signed [34:0] V_MIN = -35'sd2147483648;

  // ---------------------------------------------------------------------
  // Configuration registers and values derived from them
  // ---------------------------------------------------------------------
  alarm_type_e              alarm_type_q, alarm_type_d;
  logic signed [VAL_W-1:0]  val_zero_q, val_zero_d;
  logic signed [VAL_W-1:0]  val_full_q, val_full_d;
  logic signed [VAL_W-1:0]  offset_q, offset_d;
  logic signed [VAL_W-1:0]  set_point_q, set_point_d;
  logic signed [VAL_W-1:0]  reset_point_q, reset_point_d;
  logic [31:0]              tta_q, tta_d;
  logic [31:0]              ttr_q, ttr_d;

  logic signed [32:0]       span_d;
  logic [32:0]              span_mag_q, span_mag_d;
  logic                     span_neg_q, span_neg_d;
  logic signed [32:0]       base_q, base_d;
  logic signed [VAL_W-1:0]  lo_q, lo_d, hi_q, hi_d;

  // Decode the write and recompute derived values from the next settings
  always_comb begin
    alarm_type_d  = alarm_type_q;
    val_zero_d    = val_zero_q;
    val_full_d    = val_full_q;
    offset_d      = offset_q;
    set_point_d   = set_point_q;
    reset_point_d = reset_point_q;
    tta_d         = tta_q;
    ttr_d         = ttr_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ALARM_TYPE:     alarm_type_d  = alarm_type_e'(cfg_data_i[1:0]);
        CFG_VAL_ZERO:       val_zero_d    = $signed(cfg_data_i);
        CFG_VAL_FULL:       val_full_d    = $signed(cfg_data_i);
        CFG_VALUE_OFFSET:   offset_d      = $signed(cfg_data_i);
        CFG_SET_POINT:      set_point_d   = $signed(cfg_data_i);
        CFG_RESET_POINT:    reset_point_d = $signed(cfg_data_i);
        CFG_TIME_TO_ALARM:  tta_d         = cfg_data_i;
        CFG_TIME_TO_RETURN: ttr_d         = cfg_data_i;
        default: ;
      endcase
    end
    span_d     = 33'(val_full_d) - 33'(val_zero_d);
    span_neg_d = span_d[32];
    span_mag_d = span_neg_d ? 33'(-span_d) : 33'(span_d);
    base_d     = 33'(val_zero_d) + 33'(offset_d);
    lo_d       = (set_point_d < reset_point_d) ? set_point_d : reset_point_d;
    hi_d       = (set_point_d < reset_point_d) ? reset_point_d : set_point_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_type_q  <= ALARM_HIGH;
      val_zero_q    <= '0;
      val_full_q    <= VAL_FULL_RST;
      offset_q      <= '0;
      set_point_q   <= '0;
      reset_point_q <= '0;
      tta_q         <= '0;
      ttr_q         <= '0;
      span_mag_q    <= 33'(VAL_FULL_RST);
      span_neg_q    <= 1'b0;
      base_q        <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
    end else begin
      alarm_type_q  <= alarm_type_d;
      val_zero_q    <= val_zero_d;
      val_full_q    <= val_full_d;
      offset_q      <= offset_d;
      set_point_q   <= set_point_d;
      reset_point_q <= reset_point_d;
      tta_q         <= tta_d;
      ttr_q         <= ttr_d;
      span_mag_q    <= span_mag_d;
      span_neg_q    <= span_neg_d;
      base_q        <= base_d;
      lo_q          <= lo_d;
      hi_q          <= hi_d;
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or drains
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, ov_q;
  logic r1, r2, r3, r4, r5;
  logic ch_ok;

  assign r5 = !ov_q || out_o.ready;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_i.ready = r1;
  assign ch_ok = (int'(in_i.channel) < CHANNELS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_i.valid && ch_ok;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) ov_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: capture the transfer
  // ---------------------------------------------------------------------
  logic [CH_W-1:0]     c1_q, c2_q, c3_q, c4_q;
  logic [31:0]         now1_q, now2_q, now3_q, now4_q;
  logic [ADC_BITS-1:0] code1_q;

  always_ff @(posedge clk_i) begin
    if (r1 && in_i.valid) begin
      c1_q    <= in_i.channel;
      code1_q <= in_i.adc_code;
      now1_q  <= in_i.now_ms;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: code times span magnitude
  // ---------------------------------------------------------------------
  logic [X_W-1:0] mag2_q, mag2_d;

  assign mag2_d = X_W'(code1_q) * X_W'(span_mag_q);

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      c2_q   <= c1_q;
      now2_q <= now1_q;
      mag2_q <= mag2_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: round, then first folds of the divide by 2^ADC_BITS - 1
  // (x = a*2^N + b gives x/D = a + (a+b)/D)
  // ---------------------------------------------------------------------
  logic [X_W-1:0] x3_q, x3_d, acc3_q, acc3_d;

  always_comb begin
    logic [X_W-1:0] fa;
    x3_d   = mag2_q + HALF;
    acc3_d = '0;
    for (int k = 0; k < FOLD_A; k++) begin
      fa     = x3_d >> ADC_BITS;
      acc3_d = acc3_d + fa;
      x3_d   = fa + (x3_d & CODE_MAX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      c3_q   <= c2_q;
      now3_q <= now2_q;
      x3_q   <= x3_d;
      acc3_q <= acc3_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: finish the divide, restore sign, add base and saturate
  // ---------------------------------------------------------------------
  logic signed [VAL_W-1:0] v4_val_q, v4_val_d;

  always_comb begin
    logic [X_W-1:0]     fa;
    logic [X_W-1:0]     fx;
    logic [X_W-1:0]     facc;
    logic [32:0]        qm;
    logic signed [34:0] qs;
    logic signed [34:0] vw;
    fx   = x3_q;
    facc = acc3_q;
    for (int k = 0; k < FOLD_B; k++) begin
      fa   = fx >> ADC_BITS;
      facc = facc + fa;
      fx   = fa + (fx & CODE_MAX);
    end
    if (fx == CODE_MAX) begin
      facc = facc + X_W'(1);
    end
    qm = facc[32:0];
    qs = $signed({2'b00, qm});
    if (span_neg_q) begin
      qs = -qs;
    end
    vw = 35'(base_q) + qs;
    if (vw > V_MAX) begin
      v4_val_d = V_MAX[31:0];
    end else if (vw < V_MIN) begin
      v4_val_d = V_MIN[31:0];
    end else begin
      v4_val_d = vw[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      c4_q     <= c3_q;
      now4_q   <= now3_q;
      v4_val_q <= v4_val_d;
    end
  end

  // ---------------------------------------------------------------------
  // Alarm qualification on the way into the result register
  // ---------------------------------------------------------------------
  chan_state_t st_q [CHANNELS];
  chan_state_t st_cur, st_nxt;
  logic        cond_alarm, cond_return;
  logic        in_band;
  logic        raised, cleared;
  logic [31:0] alarm_age, return_age;

  assign in_band    = (v4_val_q >= lo_q) && (v4_val_q <= hi_q);
  assign st_cur     = st_q[c4_q];
  assign alarm_age  = now4_q - st_cur.alarm_start;
  assign return_age = now4_q - st_cur.return_start;

  // Select the alarm and return conditions for the configured kind
  always_comb begin
    case (alarm_type_q)
      ALARM_HIGH: begin
        cond_alarm  = v4_val_q >= set_point_q;
        cond_return = v4_val_q < reset_point_q;
      end
      ALARM_LOW: begin
        cond_alarm  = v4_val_q <= set_point_q;
        cond_return = v4_val_q > reset_point_q;
      end
      ALARM_IN_BAND: begin
        cond_alarm  = in_band;
        cond_return = !in_band;
      end
      ALARM_OUT_BAND: begin
        cond_alarm  = !in_band;
        cond_return = in_band;
      end
      default: begin
        cond_alarm  = 1'b0;
        cond_return = 1'b0;
      end
    endcase
  end

  // Advance the timers and flags of the channel of this reading
  always_comb begin
    st_nxt  = st_cur;
    raised  = 1'b0;
    cleared = 1'b0;
    if (cond_alarm) begin
      if (!st_cur.in_alarm) begin
        if (!st_cur.alarm_pending) begin
          st_nxt.alarm_pending = 1'b1;
          st_nxt.alarm_start   = now4_q;
        end else if (alarm_age >= tta_q) begin
          st_nxt.in_alarm       = 1'b1;
          st_nxt.return_pending = 1'b0;
          raised                = 1'b1;
        end
      end
    end else begin
      st_nxt.alarm_pending = 1'b0;
      if (st_cur.in_alarm) begin
        if (cond_return) begin
          if (!st_cur.return_pending) begin
            st_nxt.return_pending = 1'b1;
            st_nxt.return_start   = now4_q;
          end else if (return_age >= ttr_q) begin
            st_nxt.in_alarm = 1'b0;
            cleared         = 1'b1;
          end
        end else begin
          st_nxt.return_pending = 1'b0;
        end
      end
    end
  end

  // Commit channel state when the reading moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_q[i] <= '0;
      end
    end else if (r5 && v4_q) begin
      st_q[c4_q] <= st_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [CH_W-1:0]         och_q;
  logic signed [VAL_W-1:0] oval_q;
  logic                    oact_q, orais_q, oclr_q;

  always_ff @(posedge clk_i) begin
    if (r5 && v4_q) begin
      och_q   <= c4_q;
      oval_q  <= v4_val_q;
      oact_q  <= st_nxt.in_alarm;
      orais_q <= raised;
      oclr_q  <= cleared;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.channel_out   = och_q;
  assign out_o.eng_value     = oval_q;
  assign out_o.alarm_active  = oact_q;
  assign out_o.alarm_raised  = orais_q;
  assign out_o.alarm_cleared = oclr_q;

endmodule

[tb/analog_alarm_qualifier_test.sv]
`timescale 1ns / 1ps

module analog_alarm_qualifier_test;
  import aaq_pkg::*;

  localparam int       CLK_PERIOD   = 10;
  localparam int       CH_NUM       = 2;
  localparam int       ADC_W        = 12;
  localparam int       CODE_FULL    = (1 << ADC_W) - 1;
  localparam longint   VAL_MAX      = 64'sh0000_0000_7FFF_FFFF;
  localparam longint   VAL_MIN      = -VAL_MAX - 1;
  localparam int       PHASES       = 9;
  localparam int       SCANS_PER_PH = 60;
  localparam int       CHOKE_CYCLES = 60;
  localparam int       DRAIN_CYCLES = 12;
  localparam int       REPORT_MAX   = 10;

  typedef enum logic {ROW_SCAN, ROW_WRITE} row_kind_e;

  // One scan result as seen on the output channel
  typedef struct packed {
    logic               ch;
    logic signed [31:0] eng;
    logic               active;
    logic               raised;
    logic               cleared;
  } alarm_result_t;

  // Directed plan row: a register write or a scan, optionally with a typed result
  typedef struct packed {
    row_kind_e          kind;
    cfg_idx_e           idx;
    logic [31:0]        data;
    logic               ch;
    logic [ADC_W-1:0]   code;
    logic [31:0]        stamp;
    logic               typed;
    logic signed [31:0] e_eng;
    logic               e_act;
    logic               e_rse;
    logic               e_clr;
  } plan_row_t;

  localparam int PLAN_LEN = 46;

  plan_row_t plan [0:PLAN_LEN-1] = '{
    // reset settings: high alarm at zero, no delays
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd0, 32'd0, 1'b1, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd4095, 32'd0, 1'b1, 32'sd6553600,
      1'b1, 1'b1, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd2048, 32'd1, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b1, 12'd4095, 32'hFFFF_FFFF, 1'b1, 32'sd6553600,
      1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b1, 12'd0, 32'd0, 1'b1, 32'sd0, 1'b1, 1'b1, 1'b0},
    // deadband 25..50 with timers
    '{ROW_WRITE, CFG_SET_POINT, 32'd3276800, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_RESET_POINT, 32'd1638400, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_TIME_TO_ALARM, 32'd100, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_TIME_TO_RETURN, 32'd10, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd0, 32'd1000, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd1500, 32'd1005, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd0, 32'd1006, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd0, 32'd1016, 1'b1, 32'sd0, 1'b0, 1'b0, 1'b1},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd4095, 32'd2000, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd4095, 32'd2099, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd4095, 32'd2100, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    // low alarm at 30, return above 40
    '{ROW_WRITE, CFG_ALARM_TYPE, 32'(ALARM_LOW), 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_SET_POINT, 32'd1966080, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_RESET_POINT, 32'd2621440, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd4095, 32'd3000, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd4095, 32'd3010, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd0, 32'd3020, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd0, 32'd3020, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    // in-band alarm, full-range scale, saturation at both ends
    '{ROW_WRITE, CFG_ALARM_TYPE, 32'(ALARM_IN_BAND), 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_VAL_ZERO, 32'h8000_0000, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_VAL_FULL, 32'h7FFF_FFFF, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_VALUE_OFFSET, 32'h7FFF_FFFF, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_TIME_TO_ALARM, 32'hFFFF_FFFF, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b1, 12'd4095, 32'd100, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b1, 12'd4095, 32'd110, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_VALUE_OFFSET, 32'h8000_0000, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd0, 32'd300, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b1, 12'd4095, 32'd301, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    // out-of-band alarm, falling scale, band -10..10
    '{ROW_WRITE, CFG_ALARM_TYPE, 32'(ALARM_OUT_BAND), 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_VAL_ZERO, 32'h7FFF_FFFF, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_VAL_FULL, 32'h8000_0000, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_VALUE_OFFSET, 32'd0, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_SET_POINT, 32'hFFF6_0000, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_RESET_POINT, 32'h000A_0000, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_TIME_TO_ALARM, 32'd0, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_TIME_TO_RETURN, 32'hFFFF_FFFF, 1'b0, 12'd0, 32'd0, 1'b0, 32'sd0,
      1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd2047, 32'd400, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd2048, 32'd401, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd0, 32'd402, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd4095, 32'd403, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0},
    '{ROW_SCAN, CFG_ALARM_TYPE, 32'd0, 1'b0, 12'd2048, 32'd404, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  aaq_in_if  #(.CH_W(1), .ADC_W(ADC_W)) rd_if ();
  aaq_out_if #(.CH_W(1))                res_if ();

  analog_alarm_qualifier #(
    .CHANNELS(CH_NUM),
    .ADC_BITS(ADC_W)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (rd_if.sink),
    .out_o     (res_if.source)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow settings and per-channel qualification state
  alarm_type_e        mode_q;
  logic signed [31:0] scale_lo_q, scale_hi_q, offset_q, set_q, rst_q;
  logic [31:0]        t_alarm_q, t_return_q;
  chan_state_t        chan_q [CH_NUM];

  alarm_result_t status_due_q [$];
  int            mismatch_cnt;
  int            result_idx;
  int            tx_mode, rx_mode;
  bit            choke_req, choke_done;

  // Linear scaling with rounded magnitude, offset, then saturation
  function automatic logic signed [31:0] scaled_value(logic [ADC_W-1:0] code);
    longint cval, span, prod, mag, quo, sum;
    cval = code;
    span = longint'(scale_hi_q) - longint'(scale_lo_q);
    prod = cval * span;
    mag  = (prod < 0) ? -prod : prod;
    quo  = (mag + CODE_FULL / 2) / CODE_FULL;
    if (prod < 0) quo = -quo;
    sum = longint'(scale_lo_q) + quo + longint'(offset_q);
    if (sum > VAL_MAX) sum = VAL_MAX;
    if (sum < VAL_MIN) sum = VAL_MIN;
    return sum[31:0];
  endfunction

  function automatic logic alarm_cond(logic signed [31:0] v, logic signed [31:0] lo,
                                      logic signed [31:0] hi);
    case (mode_q)
      ALARM_HIGH:    return v >= set_q;
      ALARM_LOW:     return v <= set_q;
      ALARM_IN_BAND: return (v >= lo) && (v <= hi);
      default:       return (v < lo) || (v > hi);
    endcase
  endfunction

  function automatic logic return_cond(logic signed [31:0] v, logic signed [31:0] lo,
                                       logic signed [31:0] hi);
    case (mode_q)
      ALARM_HIGH:    return v < rst_q;
      ALARM_LOW:     return v > rst_q;
      ALARM_IN_BAND: return (v < lo) || (v > hi);
      default:       return (v >= lo) && (v <= hi);
    endcase
  endfunction

  // Advance one channel's alarm qualification and form its result
  function automatic alarm_result_t predict_scan(logic ch, logic [ADC_W-1:0] code,
                                                 logic [31:0] stamp);
    alarm_result_t      r;
    logic signed [31:0] v, lo, hi;
    logic [31:0]        elapsed;
    r  = '0;
    v  = scaled_value(code);
    lo = (set_q < rst_q) ? set_q : rst_q;
    hi = (set_q < rst_q) ? rst_q : set_q;
    if (alarm_cond(v, lo, hi)) begin
      if (!chan_q[ch].in_alarm) begin
        elapsed = stamp - chan_q[ch].alarm_start;
        if (!chan_q[ch].alarm_pending) begin
          chan_q[ch].alarm_pending = 1'b1;
          chan_q[ch].alarm_start   = stamp;
        end else if (elapsed >= t_alarm_q) begin
          chan_q[ch].in_alarm       = 1'b1;
          chan_q[ch].return_pending = 1'b0;
          r.raised                  = 1'b1;
        end
      end
    end else begin
      chan_q[ch].alarm_pending = 1'b0;
      if (chan_q[ch].in_alarm) begin
        if (return_cond(v, lo, hi)) begin
          elapsed = stamp - chan_q[ch].return_start;
          if (!chan_q[ch].return_pending) begin
            chan_q[ch].return_pending = 1'b1;
            chan_q[ch].return_start   = stamp;
          end else if (elapsed >= t_return_q) begin
            chan_q[ch].in_alarm = 1'b0;
            r.cleared           = 1'b1;
          end
        end else begin
          chan_q[ch].return_pending = 1'b0;
        end
      end
    end
    r.ch     = ch;
    r.eng    = v;
    r.active = chan_q[ch].in_alarm;
    return r;
  endfunction

  function automatic int draw_wait(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 17);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
    endcase
  endfunction

  // Write one register on an idle block and mirror it in the shadow copy
  task automatic write_setting(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_ALARM_TYPE:     mode_q     = alarm_type_e'(data[1:0]);
      CFG_VAL_ZERO:       scale_lo_q = data;
      CFG_VAL_FULL:       scale_hi_q = data;
      CFG_VALUE_OFFSET:   offset_q   = data;
      CFG_SET_POINT:      set_q      = data;
      CFG_RESET_POINT:    rst_q      = data;
      CFG_TIME_TO_ALARM:  t_alarm_q  = data;
      CFG_TIME_TO_RETURN: t_return_q = data;
      default: ;
    endcase
  endtask

  // Offer one reading; on transfer, queue its expected status
  task automatic send_scan(input logic ch, input logic [ADC_W-1:0] code,
                           input logic [31:0] stamp, input logic typed,
                           input alarm_result_t typed_exp);
    int            gap;
    alarm_result_t pred;
    gap = draw_wait(tx_mode);
    if (gap != 0) begin
      rd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rd_if.valid    <= 1'b1;
    rd_if.channel  <= ch;
    rd_if.adc_code <= code;
    rd_if.now_ms   <= stamp;
    do @(posedge clk_i); while (rd_if.ready !== 1'b1);
    pred = predict_scan(ch, code, stamp);
    status_due_q.push_back(typed ? typed_exp : pred);
  endtask

  // Stop offering and wait for every queued status to arrive
  task automatic drain_results();
    rd_if.valid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus: directed plan, then randomized setting phases
  initial begin : stimulus
    int            r, ph, n, jit, lvl;
    int            lo_v, hi_v, off_v, sp_v, rp_v;
    logic [31:0]   ta_v, tr_v, stamp;
    logic          ch;
    logic [ADC_W-1:0] code;
    int            level [CH_NUM];
    alarm_type_e   kind;
    alarm_result_t row_exp;

    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_ALARM_TYPE;
    cfg_data       = '0;
    rd_if.valid    = 1'b0;
    rd_if.channel  = '0;
    rd_if.adc_code = '0;
    rd_if.now_ms   = '0;
    mode_q         = ALARM_HIGH;
    scale_lo_q     = '0;
    scale_hi_q     = VAL_FULL_RST;
    offset_q       = '0;
    set_q          = '0;
    rst_q          = '0;
    t_alarm_q      = '0;
    t_return_q     = '0;
    for (r = 0; r < CH_NUM; r++) begin
      chan_q[r] = '0;
      level[r]  = $urandom_range(0, CODE_FULL);
    end
    tx_mode   = 1;
    rx_mode   = 1;
    choke_req = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed plan
    for (r = 0; r < PLAN_LEN; r++) begin
      if (plan[r].kind == ROW_WRITE) begin
        drain_results();
        write_setting(plan[r].idx, plan[r].data);
      end else begin
        row_exp = {plan[r].ch, plan[r].e_eng, plan[r].e_act, plan[r].e_rse, plan[r].e_clr};
        send_scan(plan[r].ch, plan[r].code, plan[r].stamp, plan[r].typed, row_exp);
      end
    end

    stamp = 32'd1000;
    ch    = 1'b0;
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();

      // Pick idling; the third phase bursts into a stalled receiver
      if (ph == 2) begin
        tx_mode   = 0;
        rx_mode   = 1;
        choke_req = 1'b1;
      end else begin
        tx_mode = $urandom_range(0, 2);
        rx_mode = $urandom_range(0, 2);
      end

      kind = alarm_type_e'((ph < 4) ? ph : $urandom_range(0, 3));
      case (ph)
        4: begin
          lo_v  = 32'h8000_0000;
          hi_v  = 32'h7FFF_FFFF;
          off_v = $urandom();
        end
        5: begin
          lo_v  = 32'h7FFF_FFFF;
          hi_v  = 32'h8000_0000;
          off_v = 32'h8000_0000;
        end
        6: begin
          lo_v  = $urandom();
          hi_v  = $urandom();
          off_v = $urandom();
        end
        default: begin
          lo_v  = $urandom_range(0, 26214400);
          lo_v  = lo_v - 13107200;
          hi_v  = $urandom_range(0, 26214400);
          hi_v  = hi_v - 13107200;
          off_v = $urandom_range(0, 2621440);
          off_v = off_v - 1310720;
        end
      endcase
      write_setting(CFG_ALARM_TYPE, 32'(kind));
      write_setting(CFG_VAL_ZERO, lo_v);
      write_setting(CFG_VAL_FULL, hi_v);
      write_setting(CFG_VALUE_OFFSET, off_v);

      // Thresholds land on reachable values except in the extreme phases
      case (ph)
        6: begin
          sp_v = $urandom();
          rp_v = $urandom();
        end
        7: begin
          sp_v = 32'h8000_0000;
          rp_v = 32'h7FFF_FFFF;
        end
        default: begin
          sp_v = scaled_value(ADC_W'($urandom_range(0, CODE_FULL)));
          rp_v = scaled_value(ADC_W'($urandom_range(0, CODE_FULL)));
        end
      endcase
      case (ph)
        1: begin
          ta_v = '0;
          tr_v = '0;
        end
        6: begin
          ta_v = $urandom();
          tr_v = $urandom();
        end
        default: begin
          ta_v = $urandom_range(0, 60);
          tr_v = $urandom_range(0, 60);
        end
      endcase
      write_setting(CFG_SET_POINT, sp_v);
      write_setting(CFG_RESET_POINT, rp_v);
      write_setting(CFG_TIME_TO_ALARM, ta_v);
      write_setting(CFG_TIME_TO_RETURN, tr_v);

      if (ph == 3) stamp = 32'hFFFF_FF00;
      if (ph == 6) stamp = $urandom();

      // Readings dwell near a level so conditions persist across scans
      for (n = 0; n < SCANS_PER_PH; n++) begin
        if ($urandom_range(0, 3) == 0) ch = ~ch;
        if ($urandom_range(0, 9) == 0) level[ch] = $urandom_range(0, CODE_FULL);
        if ($urandom_range(0, 9) == 0) begin
          code = ADC_W'($urandom_range(0, CODE_FULL));
        end else begin
          jit = $urandom_range(0, 40);
          lvl = level[ch] + jit - 20;
          if (lvl < 0) lvl = 0;
          if (lvl > CODE_FULL) lvl = CODE_FULL;
          code = ADC_W'(lvl);
        end
        stamp = stamp + $urandom_range(0, 25);
        send_scan(ch, code, stamp, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && status_due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, compare each transfer
  initial begin : result_sink
    int            stall;
    alarm_result_t got, want;
    res_if.ready = 1'b0;
    mismatch_cnt = 0;
    result_idx   = 0;
    choke_done   = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (choke_req && !choke_done) begin
        stall      = CHOKE_CYCLES;
        choke_done = 1'b1;
      end else begin
        stall = draw_wait(rx_mode);
      end
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);

      got = {res_if.channel_out, res_if.eng_value, res_if.alarm_active,
             res_if.alarm_raised, res_if.alarm_cleared};
      if (status_due_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("result %0d: unexpected transfer ch=%0d eng=%0d", result_idx, got.ch,
                   got.eng);
      end else begin
        want = status_due_q.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("result %0d: expected ch=%0d eng=%0d act=%b rse=%b clr=%b,",
                     result_idx, want.ch, want.eng, want.active, want.raised, want.cleared,
                     " got ch=%0d eng=%0d act=%b rse=%b clr=%b",
                     got.ch, got.eng, got.active, got.raised, got.cleared);
        end
      end
      result_idx++;
    end
  end

  // Watchdog
  initial begin : watchdog
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
hw/rtl/aaq_pkg.sv
hw/rtl/aaq_if.sv
hw/rtl/analog_alarm_qualifier.sv
tb/analog_alarm_qualifier_test.sv
